// ===== rtl/icv_pkg.sv =====
// Package for the IPv4 interface configuration validator.
// Holds the item and result types, status codes and the address-rule functions.
// No dependencies.
package icv_pkg;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_DEVICE_CONFLICT = 3'd1,
    ST_OBJECT_CONFLICT = 3'd2,
    ST_TOO_MUCH_DATA   = 3'd3,
    ST_INVALID_VALUE   = 3'd4
  } status_t;

  localparam logic [1:0] METHOD_STATIC = 2'd0;
  localparam logic [1:0] METHOD_BOOTP  = 2'd1;
  localparam logic [1:0] METHOD_DHCP   = 2'd2;

  localparam logic [8:0] HDR_BYTES = 9'd20;
  localparam logic signed [7:0] BAD_COUNT = -8'sd1;

  localparam logic [31:0] CLASS_D_MASK  = 32'hE000_0000;
  localparam logic [31:0] TOP_OCTET     = 32'hFF00_0000;
  localparam logic [31:0] LOOPBACK_NET  = 32'h7F00_0000;

  typedef struct packed {
    logic [31:0] host_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [15:0] domain_length;
    logic        io_connection_active;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               accepted;
    logic signed [7:0]  decoded_bytes;
  } result_t;

  // contiguous prefix: two's complement of the mask is a single bit
  function automatic logic mask_ok(input logic [31:0] m);
    logic [31:0] h;
    h = (~m) + 32'd1;
    return (h != 32'd0) && ((h & (h - 32'd1)) == 32'd0) && (m != 32'hFFFF_FFFF);
  endfunction

  function automatic logic class_abc(input logic [31:0] a);
    return (a & CLASS_D_MASK) != CLASS_D_MASK;
  endfunction

  function automatic logic loopback(input logic [31:0] a);
    return (a & TOP_OCTET) == LOOPBACK_NET;
  endfunction

  function automatic logic net_or_bcast(input logic [31:0] a, input logic [31:0] m);
    return ((a & m) == a) || ((a | ~m) == a);
  endfunction

endpackage

// ===== rtl/icv_if.sv =====
// Channel interfaces for the validator: request, response and configuration.
// Depends on icv_pkg for nothing but keeps field widths of the item types.
interface icv_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] host_ip;
  logic [31:0] subnet_mask;
  logic [31:0] gateway;
  logic [31:0] dns_primary;
  logic [31:0] dns_secondary;
  logic [15:0] domain_length;
  logic        io_connection_active;

  modport source (output valid, host_ip, subnet_mask, gateway, dns_primary,
                  dns_secondary, domain_length, io_connection_active,
                  input ready);
  modport sink (input valid, host_ip, subnet_mask, gateway, dns_primary,
                dns_secondary, domain_length, io_connection_active,
                output ready);
endinterface

interface icv_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status_code;
  logic              accepted;
  logic signed [7:0] decoded_bytes;
  logic              config_pending;

  modport source (output valid, status_code, accepted, decoded_bytes, config_pending,
                  input ready);
  modport sink (input valid, status_code, accepted, decoded_bytes, config_pending,
                output ready);
endinterface

interface icv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] config_method;

  modport source (output valid, config_method, input ready);
  modport sink (input valid, config_method, output ready);
endinterface

// ===== rtl/icv_check.sv =====
// Combinational rule check of one registered configuration item.
// Depends on icv_pkg (types, status codes, address-rule functions).
module icv_check
  import icv_pkg::*;
#(
  parameter int unsigned DOMAIN_MAX_LEN = 48
) (
  input  item_t      item,
  input  logic [1:0] method,
  output result_t    result
);

  logic       mask_nz;
  logic       gw_nz;
  logic       net_ok;
  logic [8:0] padded;
  logic [8:0] count;

  assign mask_nz = item.subnet_mask != 32'd0;
  assign gw_nz   = item.gateway != 32'd0;

  always_comb begin
    net_ok = 1'b1;
    if (item.host_ip == 32'd0) net_ok = 1'b0;
    if (mask_nz && !mask_ok(item.subnet_mask)) net_ok = 1'b0;
    if (!class_abc(item.host_ip) || !class_abc(item.gateway) ||
        !class_abc(item.dns_primary) || !class_abc(item.dns_secondary)) begin
      net_ok = 1'b0;
    end
    if (loopback(item.host_ip) || loopback(item.gateway)) net_ok = 1'b0;
    if (net_or_bcast(item.host_ip, item.subnet_mask)) net_ok = 1'b0;
    if (gw_nz && net_or_bcast(item.gateway, item.subnet_mask)) net_ok = 1'b0;
    if (gw_nz && mask_nz &&
        ((item.host_ip & item.subnet_mask) != (item.gateway & item.subnet_mask))) begin
      net_ok = 1'b0;
    end
  end

  // length is at most DOMAIN_MAX_LEN whenever it is used, so the low byte suffices for limits up to 255
  assign padded = ({1'b0, item.domain_length[7:0]} + 9'd1) & ~9'd1;
  assign count  = HDR_BYTES + padded;

  always_comb begin
    result.accepted      = 1'b0;
    result.decoded_bytes = BAD_COUNT;
    if (item.io_connection_active) begin
      result.status = ST_DEVICE_CONFLICT;
    end else if (method != METHOD_STATIC) begin
      result.status = ST_OBJECT_CONFLICT;
    end else if (item.domain_length > 16'(DOMAIN_MAX_LEN)) begin
      result.status = ST_TOO_MUCH_DATA;
    end else if (!net_ok) begin
      result.status = ST_INVALID_VALUE;
    end else begin
      result.status        = ST_OK;
      result.accepted      = 1'b1;
      result.decoded_bytes = signed'(count[7:0]);
    end
  end

endmodule

// ===== rtl/ipv4_interface_config_validator.sv =====
// IPv4 interface configuration validator: one proposed configuration per request
// item, one response item carrying status, accept flag, byte count and the sticky
// change-pending flag. An item is registered in the input stage on accept, checked
// by the combinational rule logic and its result registered in the output stage,
// from which the response is offered; one item is taken every cycle when the response
// side keeps ready high, with the check logic between the two registers. Request ready
// follows response ready only when both stages hold items. config_method resets to DHCP;
// the user is to write it only while the block is idle, which the block does not enforce.
// The pending flag is cleared only by reset. Depends on icv_pkg, icv_if and icv_check.
module ipv4_interface_config_validator
  import icv_pkg::*;
#(
  parameter int unsigned DOMAIN_MAX_LEN = 48
) (
  input logic         clk,
  input logic         rst,
  icv_req_if.sink     request,
  icv_rsp_if.source   response,
  icv_cfg_if.sink     cfg
);

  logic [1:0] config_method;
  logic       stage_valid;
  item_t      stage_item;
  logic       out_valid;
  result_t    out_res;
  logic       out_pending;
  logic       pending;
  logic       pending_next;
  result_t    check_res;
  logic       load_out;
  logic       req_fire;

  icv_check #(.DOMAIN_MAX_LEN(DOMAIN_MAX_LEN)) u_check (
    .item   (stage_item),
    .method (config_method),
    .result (check_res)
  );

  assign load_out       = stage_valid && (!out_valid || response.ready);
  assign request.ready  = !stage_valid || load_out;
  assign req_fire       = request.valid && request.ready;
  assign cfg.ready      = 1'b1;
  assign pending_next   = pending | (load_out & check_res.accepted);

  always_ff @(posedge clk) begin
    if (rst) begin
      config_method <= METHOD_DHCP;
      stage_valid   <= 1'b0;
      out_valid     <= 1'b0;
      pending       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) config_method <= cfg.config_method;
      if (req_fire) begin
        stage_valid <= 1'b1;
      end else if (load_out) begin
        stage_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      stage_item.host_ip              <= request.host_ip;
      stage_item.subnet_mask          <= request.subnet_mask;
      stage_item.gateway              <= request.gateway;
      stage_item.dns_primary          <= request.dns_primary;
      stage_item.dns_secondary        <= request.dns_secondary;
      stage_item.domain_length        <= request.domain_length;
      stage_item.io_connection_active <= request.io_connection_active;
    end
    if (load_out) begin
      out_res     <= check_res;
      out_pending <= pending_next;
    end
  end

  assign response.valid          = out_valid;
  assign response.status_code    = out_res.status;
  assign response.accepted       = out_res.accepted;
  assign response.decoded_bytes  = out_res.decoded_bytes;
  assign response.config_pending = out_pending;

  a_accept_sets_pending: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.accepted |-> response.config_pending)
    else $error("accepted item without pending flag");

  a_pending_sticky: assert property (@(posedge clk) disable iff (rst)
    pending |=> pending)
    else $error("pending flag cleared without reset");

  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.accepted |-> response.decoded_bytes == BAD_COUNT)
    else $error("rejected item carries a byte count");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !response.ready |=> out_valid)
    else $error("stalled result dropped");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> stage_valid)
    else $error("accepted item not held in input stage");

endmodule

// ===== sim/tb_ipv4_interface_config_validator.sv =====
`timescale 1ns / 100ps
// Testbench for ipv4_interface_config_validator: directed and random configurations,
// each response checked against a local model of the rule chain and the pending flag.
// Depends on icv_pkg, icv_if and the validator RTL.
module tb_ipv4_interface_config_validator;
  import icv_pkg::*;

  localparam int DOMAIN_LIMIT = 48;
  localparam logic [1:0] METHOD_UNUSED = 2'd3;
  localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    status_t           status;
    logic              accepted;
    logic signed [7:0] count;
    logic              pending;
  } outcome_t;

  logic clk;
  logic rst;

  icv_req_if req_ch ();
  icv_rsp_if rsp_ch ();
  icv_cfg_if cfg_ch ();

  ipv4_interface_config_validator #(
    .DOMAIN_MAX_LEN(DOMAIN_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch),
    .cfg      (cfg_ch)
  );

  item_t    request_backlog[$];
  outcome_t awaited_outcomes[$];
  item_t    drive_item;
  logic     req_taken;
  logic     rsp_hold;
  bit       hold_go;
  int       send_gap_pct;
  int       rsp_stall_pct;
  int       items_queued;
  int       outcomes_seen;
  int       mismatches;

  // model state
  logic [1:0] method_now;
  logic       pending_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic is_edge_address(input logic [31:0] a, input logic [31:0] m);
    return ((a & m) == a) || ((a | ~m) == a);
  endfunction

  function automatic outcome_t judge_config(input item_t it);
    outcome_t   o;
    logic       bad;
    logic [31:0] inv;
    logic [8:0] padded;
    logic [8:0] total;
    o.status = ST_OK;
    o.accepted = 1'b0;
    o.count = BAD_COUNT;
    bad = (it.host_ip == 32'd0);
    if (it.subnet_mask != 32'd0) begin
      inv = ~it.subnet_mask;
      // mask must be ones then zeros, with at least one host bit
      bad |= (inv == 32'd0) || ((inv & (inv + 32'd1)) != 32'd0);
    end
    bad |= (it.host_ip[31:29] == 3'b111) || (it.gateway[31:29] == 3'b111) ||
           (it.dns_primary[31:29] == 3'b111) || (it.dns_secondary[31:29] == 3'b111);
    bad |= (it.host_ip[31:24] == LOOPBACK_OCTET) || (it.gateway[31:24] == LOOPBACK_OCTET);
    bad |= is_edge_address(it.host_ip, it.subnet_mask);
    bad |= (it.gateway != 32'd0) && is_edge_address(it.gateway, it.subnet_mask);
    bad |= (it.gateway != 32'd0) && (it.subnet_mask != 32'd0) &&
           (((it.host_ip ^ it.gateway) & it.subnet_mask) != 32'd0);
    if (it.io_connection_active) begin
      o.status = ST_DEVICE_CONFLICT;
    end else if (method_now != METHOD_STATIC) begin
      o.status = ST_OBJECT_CONFLICT;
    end else if (it.domain_length > DOMAIN_LIMIT) begin
      o.status = ST_TOO_MUCH_DATA;
    end else if (bad) begin
      o.status = ST_INVALID_VALUE;
    end else begin
      padded = (it.domain_length[8:0] + 9'd1) & ~9'd1;
      total = padded + HDR_BYTES;
      o.accepted = 1'b1;
      o.count = total[7:0];
      pending_now = 1'b1;
    end
    o.pending = pending_now;
    return o;
  endfunction

  function automatic item_t cfg_item(input logic [31:0] ip, input logic [31:0] m,
                                     input logic [31:0] gw, input logic [31:0] ns1,
                                     input logic [31:0] ns2, input logic [15:0] dlen,
                                     input logic io);
    item_t it;
    it.host_ip = ip;
    it.subnet_mask = m;
    it.gateway = gw;
    it.dns_primary = ns1;
    it.dns_secondary = ns2;
    it.domain_length = dlen;
    it.io_connection_active = io;
    return it;
  endfunction

  // mostly well-formed configurations, some with one rule broken, some pure noise
  function automatic item_t random_config();
    item_t       it;
    int          prefix;
    logic [31:0] m;
    logic [31:0] hosts;
    logic [31:0] r;
    logic [7:0]  top;
    if ($urandom_range(99, 0) < 10) begin
      return cfg_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)));
    end
    prefix = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(30, 8);
    m = (prefix == 0) ? 32'd0 : ~32'd0 << (32 - prefix);
    hosts = ~m;
    top = 8'($urandom_range(223, 1));
    if (top == LOOPBACK_OCTET) top = 8'd126;
    r = $urandom();
    it.host_ip = {top, r[23:0]};
    it.subnet_mask = m;
    if (m != 32'd0) begin
      r = $urandom() & hosts;
      if (r == 32'd0) r = 32'd1;
      else if (r == hosts) r = hosts - 32'd1;
      it.host_ip = (it.host_ip & m) | r;
      r = $urandom() & hosts;
      if (r == 32'd0) r = 32'd1;
      else if (r == hosts) r = hosts - 32'd1;
      it.gateway = (it.host_ip & m) | r;
    end else begin
      r = $urandom();
      it.gateway = {8'($urandom_range(126, 1)), r[23:0]};
    end
    if ($urandom_range(3, 0) == 0) it.gateway = 32'd0;
    it.dns_primary = $urandom();
    if (it.dns_primary[31:29] == 3'b111) it.dns_primary[31] = 1'b0;
    it.dns_secondary = $urandom();
    if (it.dns_secondary[31:29] == 3'b111) it.dns_secondary[31] = 1'b0;
    it.domain_length = 16'($urandom_range(DOMAIN_LIMIT, 0));
    it.io_connection_active = 1'b0;
    if ($urandom_range(99, 0) < 35) begin
      case ($urandom_range(11, 0))
        0: it.io_connection_active = 1'b1;
        1: it.domain_length = 16'($urandom_range(65535, DOMAIN_LIMIT + 1));
        2: it.host_ip = 32'd0;
        3: it.subnet_mask = 32'hFFFF_FFFF;
        4: it.subnet_mask ^= 32'd1 << $urandom_range(31, 0);
        5: it.host_ip &= m;
        6: it.host_ip |= ~m;
        7: it.gateway |= ~m;
        8: it.gateway ^= 32'h0040_0000;
        9: it.dns_primary[31:29] = 3'b111;
        10: it.dns_secondary[31:29] = 3'b111;
        default: begin
          if ($urandom_range(1, 0) == 0) it.host_ip[31:24] = LOOPBACK_OCTET;
          else it.gateway[31:24] = LOOPBACK_OCTET;
        end
      endcase
    end
    return it;
  endfunction

  task automatic enqueue(input item_t it);
    request_backlog.push_back(it);
    items_queued++;
  endtask

  // every item gives one response, so idle means all responses are in
  task automatic wait_drained();
    while (outcomes_seen < items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_method(input logic [1:0] method);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.config_method <= method;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (request_backlog.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
        drive_item = request_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.host_ip <= drive_item.host_ip;
        req_ch.subnet_mask <= drive_item.subnet_mask;
        req_ch.gateway <= drive_item.gateway;
        req_ch.dns_primary <= drive_item.dns_primary;
        req_ch.dns_secondary <= drive_item.dns_secondary;
        req_ch.domain_length <= drive_item.domain_length;
        req_ch.io_connection_active <= drive_item.io_connection_active;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= !rsp_hold && ($urandom_range(99, 0) >= rsp_stall_pct);
  end

  // long receiver stall while the sender keeps offering
  initial begin
    rsp_hold = 1'b0;
    wait (hold_go);
    @(negedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rsp_hold <= 1'b0;
  end

  // monitor: config and request items feed the model, responses are checked
  always @(posedge clk) begin : watch
    outcome_t head;
    item_t    taken;
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) method_now = cfg_ch.config_method;
      if (rsp_ch.valid && rsp_ch.ready) begin
        outcomes_seen++;
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response: status %0d accepted %0b bytes %0d pending %0b",
                   $time, rsp_ch.status_code, rsp_ch.accepted, rsp_ch.decoded_bytes,
                   rsp_ch.config_pending);
        end else begin
          head = awaited_outcomes.pop_front();
          if (head.status != rsp_ch.status_code || head.accepted != rsp_ch.accepted ||
              head.count != rsp_ch.decoded_bytes || head.pending != rsp_ch.config_pending)
          begin
            mismatches++;
            $display("%0t: mismatch: expected status %0d accepted %0b bytes %0d pending %0b,",
                     $time, head.status, head.accepted, head.count, head.pending);
            $display("%0t:           actual status %0d accepted %0b bytes %0d pending %0b",
                     $time, rsp_ch.status_code, rsp_ch.accepted, rsp_ch.decoded_bytes,
                     rsp_ch.config_pending);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        taken.host_ip = req_ch.host_ip;
        taken.subnet_mask = req_ch.subnet_mask;
        taken.gateway = req_ch.gateway;
        taken.dns_primary = req_ch.dns_primary;
        taken.dns_secondary = req_ch.dns_secondary;
        taken.domain_length = req_ch.domain_length;
        taken.io_connection_active = req_ch.io_connection_active;
        awaited_outcomes.push_back(judge_config(taken));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [1:0] other_method[3];
    int         send_pct[3];
    int         stall_pct[3];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.host_ip = '0;
    req_ch.subnet_mask = '0;
    req_ch.gateway = '0;
    req_ch.dns_primary = '0;
    req_ch.dns_secondary = '0;
    req_ch.domain_length = '0;
    req_ch.io_connection_active = 1'b0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.config_method = METHOD_STATIC;
    req_taken = 1'b0;
    hold_go = 1'b0;
    send_gap_pct = 0;
    rsp_stall_pct = 0;
    items_queued = 0;
    outcomes_seen = 0;
    mismatches = 0;
    method_now = METHOD_DHCP;
    pending_now = 1'b0;
    other_method = '{METHOD_BOOTP, METHOD_UNUSED, METHOD_DHCP};
    send_pct = '{12, 85, 0};
    stall_pct = '{85, 12, 0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // method after reset is DHCP: refused, with a device conflict when an IO connection is open
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd10, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd10, 1'b1));
    wait_drained();
    write_method(METHOD_STATIC);
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd0, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd48, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd47, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd1, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd49, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'hFFFF, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'hFFFF, 1'b1));
    enqueue(cfg_item(32'h0, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FFFF, 32'h0, 32'h0808_0808,
                     32'h0101_0101, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFF00_FF00, 32'h0, 32'h0808_0808,
                     32'h0101_0101, 16'd4, 1'b0));
    // no mask: only the address rules apply
    enqueue(cfg_item(32'h0A01_0203, 32'h0, 32'h0, 32'h0, 32'h0, 16'd7, 1'b0));
    enqueue(cfg_item(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 16'd7, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'hE000_0001,
                     32'h0101_0101, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'hFFFF_FFFF, 16'd4, 1'b0));
    enqueue(cfg_item(32'h7F00_0001, 32'hFF00_0000, 32'h0, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'h0, 32'h7F00_0001, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_0100, 32'hFFFF_FF00, 32'h0, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_01FF, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0201, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'h4000_0001, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 16'd4, 1'b0));
    enqueue(cfg_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 1'b0));
    wait_drained();
    // method code three is not static either
    write_method(METHOD_UNUSED);
    enqueue(cfg_item(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0808_0808,
                     32'h0101_0101, 16'd10, 1'b0));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      write_method(METHOD_STATIC);
      send_gap_pct = send_pct[ph];
      rsp_stall_pct = stall_pct[ph];
      for (int n = 0; n < 535; n++) enqueue(random_config());
      if (ph == 2) hold_go = 1'b1;
      wait_drained();
      write_method(other_method[ph]);
      for (int n = 0; n < 40; n++) enqueue(random_config());
      wait_drained();
    end

    repeat (16) @(negedge clk);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
